>>> rtl/core/nrmc_pkg.sv
// Shared types, character codes and field numbers of the RMC sentence parser.
package nrmc_pkg;

   // Character codes.
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_E      = 8'h45;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_V      = 8'h56;
   localparam logic [7:0] CHAR_W      = 8'h57;

   // "GPRM": the four bytes that must precede the final 'C' of the tag.
   localparam logic [31:0] TAG_HEAD = 32'h4750_524D;

   // Field numbers, counted by commas.
   localparam logic [3:0] FIELD_TIME     = 4'd1;
   localparam logic [3:0] FIELD_STATUS   = 4'd2;
   localparam logic [3:0] FIELD_LAT      = 4'd3;
   localparam logic [3:0] FIELD_LAT_HEMI = 4'd4;
   localparam logic [3:0] FIELD_LON      = 4'd5;
   localparam logic [3:0] FIELD_LON_HEMI = 4'd6;
   localparam logic [3:0] FIELD_DATE     = 4'd9;
   localparam logic [3:0] FIELD_MAX      = 4'd15;

   // Position inside a numeric field.
   localparam logic [3:0] PHASE_INT      = 4'd0;
   localparam logic [3:0] PHASE_FRAC0    = 4'd1;
   localparam logic [3:0] PHASE_FRAC_MAX = 4'd7;
   localparam logic [3:0] PHASE_DONE     = 4'd15;

   localparam logic [2:0]  COUNT_MIN = 3'd4;
   localparam logic [19:0] DEC_MAX   = 20'd999999;
   localparam logic [30:0] COORD_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic       fire;
      logic [7:0] rx_data;
   } byte_step_type;

   typedef struct packed {
      logic               fix;
      logic [19:0]        time_int;
      logic [9:0]         millis;
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      logic [19:0]        date;
   } fix_record_type;

   typedef struct packed {
      logic           ok;
      fix_record_type rec;
   } line_summary_type;

   typedef struct packed {
      logic fix;
      logic lat_neg;
      logic lat_zero;
      logic lon_neg;
      logic lon_zero;
   } line_flags_type;

   function automatic logic [19:0] pow_ten(input int n);
      logic [19:0] r;
      case (n)
         0:       r = 20'd1;
         1:       r = 20'd10;
         2:       r = 20'd100;
         3:       r = 20'd1000;
         4:       r = 20'd10000;
         5:       r = 20'd100000;
         default: r = 20'd1000000;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/nmea_rmc_sentence_parser_unit.sv
// Top level of the NMEA RMC sentence parser.
//
// The block takes one received character per transfer on the req_ channel and returns one
// result per line on the rsp_ channel. A '$' is dropped, a newline ends the line, and every
// other byte joins it. At the newline the line is accepted as an RMC sentence when the byte
// four before the end is '*', the text GPRMC occurs in it, at least nine commas were seen,
// and the status and hemisphere fields are well formed. An accepted line replaces the
// stored fix record; every newline yields one result that carries the accept flag and the
// record as it stands after that line.
//
// A byte is registered in the input register and parsed from there; a newline's result is
// registered in the output register before it shows on the rsp_ ports. Throughput is one
// byte per cycle, while no newline waits in the input register for a stalled result.
//
// Reset clears the line state and the stored record to zero and empties both registers.
// When the receiver stalls, a finished result waits in the output register while ordinary
// bytes keep flowing; only a second newline waits in the input register until the pending
// result has been taken, and req_ready drops behind it.
module nmea_rmc_sentence_parser_unit
   import nrmc_pkg::*;
#(
   parameter int COORD_FRAC_DIGITS = 4,
   parameter int TIME_FRAC_DIGITS  = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_sentence_ok,
   output logic               rsp_fix_valid,
   output logic [19:0]        rsp_time_hhmmss,
   output logic [9:0]         rsp_time_millis,
   output logic signed [31:0] rsp_latitude_e4,
   output logic signed [31:0] rsp_longitude_e4,
   output logic [19:0]        rsp_date_ddmmyy
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   logic             out_free;
   logic             step_fire;
   logic             line_end;
   byte_step_type    step;
   line_summary_type summary;
   fix_record_type   rsp_rec;

   // A newline may only leave the input register when the result register can take it.
   assign out_free  = !rsp_valid || rsp_ready;
   assign step_fire = in_valid_ff && ((in_byte_ff != CHAR_LF) || out_free);
   assign line_end  = step_fire && (in_byte_ff == CHAR_LF);
   assign req_ready = !in_valid_ff || step_fire;

   assign step.fire    = step_fire;
   assign step.rx_data = in_byte_ff;

   always_comb begin
      in_valid_in = in_valid_ff && !step_fire;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   nrmc_line_parser #(
      .COORD_FRAC_DIGITS(COORD_FRAC_DIGITS),
      .TIME_FRAC_DIGITS (TIME_FRAC_DIGITS)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .summary(summary)
   );

   nrmc_fix_record u_record (
      .clock          (clock),
      .reset          (reset),
      .line_end       (line_end),
      .summary        (summary),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_sentence_ok(rsp_sentence_ok),
      .rsp_rec        (rsp_rec)
   );

   assign rsp_fix_valid    = rsp_rec.fix;
   assign rsp_time_hhmmss  = rsp_rec.time_int;
   assign rsp_time_millis  = rsp_rec.millis;
   assign rsp_latitude_e4  = rsp_rec.lat;
   assign rsp_longitude_e4 = rsp_rec.lon;
   assign rsp_date_ddmmyy  = rsp_rec.date;

endmodule

>>> rtl/core/nrmc_line_parser.sv
// Per-line field parser: tracks the line, accumulates numbers and summarizes at line end.
module nrmc_line_parser
   import nrmc_pkg::*;
#(
   parameter int COORD_FRAC_DIGITS = 4,
   parameter int TIME_FRAC_DIGITS  = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  byte_step_type    step,
   output line_summary_type summary
);

   localparam logic [19:0] COORD_INT_WEIGHT = pow_ten(COORD_FRAC_DIGITS);

   logic [2:0]     line_count_ff, line_count_in;
   logic [31:0]    tail_ff, tail_in;
   logic           tag_ff, tag_in;
   logic [3:0]     field_ff, field_in;
   logic           bad_ff, bad_in;
   logic [3:0]     phase_ff, phase_in;
   logic [19:0]    time_int_ff, time_int_in;
   logic [9:0]     millis_ff, millis_in;
   logic [30:0]    lat_ff, lat_in;
   logic [30:0]    lon_ff, lon_in;
   logic [19:0]    date_ff, date_in;
   line_flags_type flags_ff, flags_in;

   logic [7:0]  c;
   logic        is_digit;
   logic [3:0]  dval;
   logic [3:0]  frac_next;
   logic [23:0] time_sum;
   logic [23:0] date_sum;

   // Weight of a coordinate fraction digit at the given phase; zero past the kept digits.
   function automatic logic [19:0] coord_weight(input logic [3:0] phase);
      int k;
      logic [19:0] w;
      k = int'(phase) - 1;
      w = 20'd0;
      if (k < COORD_FRAC_DIGITS && k < 6)
         w = pow_ten(COORD_FRAC_DIGITS - 1 - k);
      return w;
   endfunction

   function automatic logic [9:0] time_weight(input logic [3:0] phase);
      int k;
      logic [9:0] w;
      k = int'(phase) - 1;
      w = 10'd0;
      if (k < TIME_FRAC_DIGITS && k < 3)
         w = 10'(pow_ten(2 - k));
      return w;
   endfunction

   function automatic logic [30:0] coord_next(input logic [30:0] acc, input logic [3:0] d,
                                              input logic [3:0] phase);
      logic [35:0] sum;
      if (phase == PHASE_INT)
         sum = 36'({acc, 3'b000}) + 36'({acc, 1'b0}) + 36'(d) * 36'(COORD_INT_WEIGHT);
      else
         sum = 36'(acc) + 36'(d) * 36'(coord_weight(phase));
      return (sum > 36'(COORD_MAX)) ? COORD_MAX : sum[30:0];
   endfunction

   assign c         = step.rx_data;
   assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign dval      = 4'(c - CHAR_ZERO);
   assign frac_next = (phase_ff < PHASE_FRAC_MAX) ? phase_ff + 4'd1 : phase_ff;
   assign time_sum  = 24'({time_int_ff, 3'b000}) + 24'({time_int_ff, 1'b0}) + 24'(dval);
   assign date_sum  = 24'({date_ff, 3'b000}) + 24'({date_ff, 1'b0}) + 24'(dval);

   always_comb begin
      line_count_in = line_count_ff;
      tail_in       = tail_ff;
      tag_in        = tag_ff;
      field_in      = field_ff;
      bad_in        = bad_ff;
      phase_in      = phase_ff;
      time_int_in   = time_int_ff;
      millis_in     = millis_ff;
      lat_in        = lat_ff;
      lon_in        = lon_ff;
      date_in       = date_ff;
      flags_in      = flags_ff;

      if (step.fire && c != CHAR_DOLLAR) begin
         if (c == CHAR_LF) begin
            line_count_in = '0;
            tail_in       = '0;
            tag_in        = 1'b0;
            field_in      = '0;
            bad_in        = 1'b0;
            phase_in      = PHASE_INT;
            time_int_in   = '0;
            millis_in     = '0;
            lat_in        = '0;
            lon_in        = '0;
            date_in       = '0;
            flags_in      = '0;
         end else begin
            if (c == CHAR_C && tail_ff == TAG_HEAD)
               tag_in = 1'b1;
            tail_in = {tail_ff[23:0], c};
            if (line_count_ff < COUNT_MIN)
               line_count_in = line_count_ff + 3'd1;

            if (c == CHAR_COMMA) begin
               // An empty field closes here with its phase still at zero.
               if (phase_ff == PHASE_INT) begin
                  case (field_ff)
                     FIELD_STATUS:   bad_in            = 1'b1;
                     FIELD_LAT_HEMI: flags_in.lat_zero = 1'b1;
                     FIELD_LON_HEMI: flags_in.lon_zero = 1'b1;
                     default: ;
                  endcase
               end
               if (field_ff < FIELD_MAX)
                  field_in = field_ff + 4'd1;
               phase_in = PHASE_INT;
            end else begin
               case (field_ff)
                  FIELD_TIME: begin
                     if (phase_ff != PHASE_DONE) begin
                        if (is_digit) begin
                           if (phase_ff == PHASE_INT) begin
                              time_int_in = (time_sum > 24'(DEC_MAX)) ? DEC_MAX
                                                                     : time_sum[19:0];
                           end else begin
                              millis_in = millis_ff + 10'(dval) * time_weight(phase_ff);
                              phase_in  = frac_next;
                           end
                        end else if (c == CHAR_DOT && phase_ff == PHASE_INT) begin
                           phase_in = PHASE_FRAC0;
                        end else begin
                           phase_in = PHASE_DONE;
                        end
                     end
                  end
                  FIELD_STATUS: begin
                     if (phase_ff == PHASE_INT) begin
                        if (c == CHAR_A)
                           flags_in.fix = 1'b1;
                        else if (c != CHAR_V)
                           bad_in = 1'b1;
                        phase_in = PHASE_FRAC0;
                     end
                  end
                  FIELD_LAT, FIELD_LON: begin
                     if (phase_ff != PHASE_DONE) begin
                        if (is_digit) begin
                           if (field_ff == FIELD_LAT)
                              lat_in = coord_next(lat_ff, dval, phase_ff);
                           else
                              lon_in = coord_next(lon_ff, dval, phase_ff);
                           if (phase_ff != PHASE_INT)
                              phase_in = frac_next;
                        end else if (c == CHAR_DOT && phase_ff == PHASE_INT) begin
                           phase_in = PHASE_FRAC0;
                        end else begin
                           phase_in = PHASE_DONE;
                        end
                     end
                  end
                  FIELD_LAT_HEMI: begin
                     if (phase_ff == PHASE_INT) begin
                        if (c == CHAR_S)
                           flags_in.lat_neg = 1'b1;
                        else if (c != CHAR_N)
                           bad_in = 1'b1;
                        phase_in = PHASE_FRAC0;
                     end
                  end
                  FIELD_LON_HEMI: begin
                     if (phase_ff == PHASE_INT) begin
                        if (c == CHAR_W)
                           flags_in.lon_neg = 1'b1;
                        else if (c != CHAR_E)
                           bad_in = 1'b1;
                        phase_in = PHASE_FRAC0;
                     end
                  end
                  FIELD_DATE: begin
                     // The date has no fraction: a dot ends the number.
                     if (phase_ff != PHASE_DONE) begin
                        if (is_digit)
                           date_in = (date_sum > 24'(DEC_MAX)) ? DEC_MAX : date_sum[19:0];
                        else
                           phase_in = PHASE_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
         tail_ff       <= '0;
         tag_ff        <= 1'b0;
         field_ff      <= '0;
         bad_ff        <= 1'b0;
         phase_ff      <= PHASE_INT;
         time_int_ff   <= '0;
         millis_ff     <= '0;
         lat_ff        <= '0;
         lon_ff        <= '0;
         date_ff       <= '0;
         flags_ff      <= '0;
      end else begin
         line_count_ff <= line_count_in;
         tail_ff       <= tail_in;
         tag_ff        <= tag_in;
         field_ff      <= field_in;
         bad_ff        <= bad_in;
         phase_ff      <= phase_in;
         time_int_ff   <= time_int_in;
         millis_ff     <= millis_in;
         lat_ff        <= lat_in;
         lon_ff        <= lon_in;
         date_ff       <= date_in;
         flags_ff      <= flags_in;
      end
   end

   always_comb begin
      summary.ok = (line_count_ff >= COUNT_MIN) && (tail_ff[31:24] == CHAR_STAR) && tag_ff &&
                   (field_ff >= FIELD_DATE) && !bad_ff;
      summary.rec.fix      = flags_ff.fix;
      summary.rec.time_int = time_int_ff;
      summary.rec.millis   = millis_ff;
      summary.rec.date     = date_ff;
      if (flags_ff.lat_zero)
         summary.rec.lat = '0;
      else if (flags_ff.lat_neg)
         summary.rec.lat = -$signed(32'(lat_ff));
      else
         summary.rec.lat = $signed(32'(lat_ff));
      if (flags_ff.lon_zero)
         summary.rec.lon = '0;
      else if (flags_ff.lon_neg)
         summary.rec.lon = -$signed(32'(lon_ff));
      else
         summary.rec.lon = $signed(32'(lon_ff));
   end

endmodule

>>> rtl/core/nrmc_fix_record.sv
// Stored fix record and the registered result channel.
module nrmc_fix_record
   import nrmc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               line_end,
   input  line_summary_type   summary,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_sentence_ok,
   output fix_record_type     rsp_rec
);

   fix_record_type record_ff, record_in;
   fix_record_type rsp_rec_ff, rsp_rec_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   fix_record_type rec_next;

   assign rec_next = summary.ok ? summary.rec : record_ff;

   always_comb begin
      record_in    = record_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (line_end) begin
         record_in    = rec_next;
         rsp_rec_in   = rec_next;
         rsp_ok_in    = summary.ok;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         record_ff    <= record_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rec_ff <= rsp_rec_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sentence_ok = rsp_ok_ff;
   assign rsp_rec         = rsp_rec_ff;

endmodule

>>> rtl/core/nrmc_checker.sv
// Port-level checker for the RMC sentence parser, bound to the top level.
module nrmc_checker
   import nrmc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_rx_byte,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_sentence_ok,
   input logic               rsp_fix_valid,
   input logic [19:0]        rsp_time_hhmmss,
   input logic [9:0]         rsp_time_millis,
   input logic signed [31:0] rsp_latitude_e4,
   input logic signed [31:0] rsp_longitude_e4,
   input logic [19:0]        rsp_date_ddmmyy
);

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // The input side never stalls while the result side can take a transfer.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled with a free result register");

   // A fresh result comes from a newline that was accepted on the input side before it.
   a_result_from_newline: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_rx_byte == CHAR_LF, 2))
      else $error("result without a preceding newline");

   // Saturated fields stay within their ranges.
   a_field_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_time_hhmmss <= DEC_MAX) && (rsp_date_ddmmyy <= DEC_MAX) &&
                    (rsp_time_millis <= 10'd999) && (rsp_latitude_e4 != 32'sh8000_0000) &&
                    (rsp_longitude_e4 != 32'sh8000_0000))
      else $error("result field out of range");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sentence_ok) &&
                                 $stable(rsp_fix_valid) && $stable(rsp_time_hhmmss) &&
                                 $stable(rsp_time_millis) && $stable(rsp_latitude_e4) &&
                                 $stable(rsp_longitude_e4) && $stable(rsp_date_ddmmyy))
      else $error("stalled result changed");

endmodule

bind nmea_rmc_sentence_parser_unit nrmc_checker u_nrmc_checker (.*);

>>> dv/rmc_line_checker.sv
// Scoreboard of the RMC sentence parser: predicts one fix result per line end and compares.
`timescale 1ns / 100ps

module rmc_line_checker
   import nrmc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_sentence_ok,
   input  logic               rsp_fix_valid,
   input  logic [19:0]        rsp_time_hhmmss,
   input  logic [9:0]         rsp_time_millis,
   input  logic signed [31:0] rsp_latitude_e4,
   input  logic signed [31:0] rsp_longitude_e4,
   input  logic [19:0]        rsp_date_ddmmyy,
   output int                 fault_total,
   output int                 lines_outstanding
);

   localparam int COORD_FRAC = 4;
   localparam int TIME_FRAC  = 3;
   localparam int PRINT_CAP  = 40;

   typedef enum {MARK_FIX, MARK_LAT_NEG, MARK_LON_NEG} mark_sel_e;

   // Per-line parse state.
   logic [2:0]     line_len;
   logic [31:0]    last_four;
   logic           gprmc_seen;
   logic [3:0]     comma_count;
   logic           line_rejected;
   logic [3:0]     num_pos;
   logic [29:0]    acc_time;
   logic [31:0]    acc_lat;
   logic [31:0]    acc_lon;
   logic [19:0]    acc_date;
   line_flags_type line_marks;

   // Stored fix and the results still owed by the block.
   fix_record_type   stored_fix;
   line_summary_type expected_lines[$];

   function automatic longint unsigned decade(int n);
      longint unsigned r;
      r = 1;
      for (int i = 0; i < n; i++) r = r * 10;
      return r;
   endfunction

   function automatic void clear_line();
      line_len      = '0;
      last_four     = '0;
      gprmc_seen    = 1'b0;
      comma_count   = '0;
      line_rejected = 1'b0;
      num_pos       = PHASE_INT;
      acc_time      = '0;
      acc_lat       = '0;
      acc_lon       = '0;
      acc_date      = '0;
      line_marks    = '0;
   endfunction

   // Returns the digit value, or -1 when the byte adds nothing to the number.
   function automatic int next_digit(logic [7:0] c, bit frac_ok);
      if (num_pos == PHASE_DONE) return -1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c == CHAR_DOT && frac_ok && num_pos == PHASE_INT) begin
         num_pos = PHASE_FRAC0;
         return -1;
      end
      num_pos = PHASE_DONE;
      return -1;
   endfunction

   function automatic void step_frac();
      if (num_pos < PHASE_FRAC_MAX) num_pos = num_pos + 4'd1;
   endfunction

   function automatic logic [31:0] coord_step(logic [31:0] acc, logic [7:0] c);
      int              d;
      int              k;
      longint unsigned v;
      d = next_digit(c, 1'b1);
      if (d < 0) return acc;
      v = acc;
      if (num_pos == PHASE_INT) begin
         v = v * 10 + d * decade(COORD_FRAC);
      end else begin
         k = int'(num_pos) - 1;
         if (k < COORD_FRAC) v = v + d * decade(COORD_FRAC - 1 - k);
         step_frac();
      end
      return (v > COORD_MAX) ? {1'b0, COORD_MAX} : v[31:0];
   endfunction

   function automatic void time_step(logic [7:0] c);
      int          d;
      int          k;
      int unsigned whole;
      int unsigned part;
      d = next_digit(c, 1'b1);
      if (d < 0) return;
      whole = acc_time / 1000;
      part  = acc_time % 1000;
      if (num_pos == PHASE_INT) begin
         whole = whole * 10 + d;
         if (whole > DEC_MAX) whole = DEC_MAX;
      end else begin
         k = int'(num_pos) - 1;
         if (k < TIME_FRAC) part = part + d * decade(2 - k);
         step_frac();
      end
      acc_time = whole * 1000 + part;
   endfunction

   // The date takes no fraction, so a dot simply ends it.
   function automatic void date_step(logic [7:0] c);
      int          d;
      int unsigned n;
      d = next_digit(c, 1'b0);
      if (d < 0) return;
      n = acc_date * 10 + d;
      acc_date = (n > DEC_MAX) ? DEC_MAX : n[19:0];
   endfunction

   // Status and hemisphere fields: only the first character counts.
   function automatic void mark_step(logic [7:0] c, logic [7:0] flag_ch, logic [7:0] plain_ch,
                                     mark_sel_e sel);
      if (num_pos != PHASE_INT) return;
      if (c == flag_ch) begin
         case (sel)
            MARK_FIX:     line_marks.fix = 1'b1;
            MARK_LAT_NEG: line_marks.lat_neg = 1'b1;
            default:      line_marks.lon_neg = 1'b1;
         endcase
      end else if (c != plain_ch) begin
         line_rejected = 1'b1;
      end
      num_pos = PHASE_FRAC0;
   endfunction

   function automatic void take_byte(logic [7:0] c);
      if (c == CHAR_C && last_four == TAG_HEAD) gprmc_seen = 1'b1;
      last_four = {last_four[23:0], c};
      if (line_len < 3'd7) line_len = line_len + 3'd1;
      if (c == CHAR_COMMA) begin
         if (num_pos == PHASE_INT) begin
            case (comma_count)
               FIELD_STATUS:   line_rejected = 1'b1;
               FIELD_LAT_HEMI: line_marks.lat_zero = 1'b1;
               FIELD_LON_HEMI: line_marks.lon_zero = 1'b1;
               default: ;
            endcase
         end
         if (comma_count != FIELD_MAX) comma_count = comma_count + 4'd1;
         num_pos = PHASE_INT;
      end else begin
         case (comma_count)
            FIELD_TIME:     time_step(c);
            FIELD_STATUS:   mark_step(c, CHAR_A, CHAR_V, MARK_FIX);
            FIELD_LAT:      acc_lat = coord_step(acc_lat, c);
            FIELD_LAT_HEMI: mark_step(c, CHAR_S, CHAR_N, MARK_LAT_NEG);
            FIELD_LON:      acc_lon = coord_step(acc_lon, c);
            FIELD_LON_HEMI: mark_step(c, CHAR_W, CHAR_E, MARK_LON_NEG);
            FIELD_DATE:     date_step(c);
            default: ;
         endcase
      end
   endfunction

   function automatic logic [31:0] signed_mag(logic [31:0] mag, logic neg, logic zero);
      if (zero) return '0;
      return neg ? -mag : mag;
   endfunction

   function automatic void finish_line();
      line_summary_type s;
      int unsigned      t;
      s.ok = line_len >= COUNT_MIN && last_four[31:24] == CHAR_STAR && gprmc_seen &&
             comma_count >= FIELD_DATE && !line_rejected;
      if (s.ok) begin
         t = acc_time / 1000;
         stored_fix.time_int = t[19:0];
         t = acc_time % 1000;
         stored_fix.millis = t[9:0];
         stored_fix.fix    = line_marks.fix;
         stored_fix.lat    = signed_mag(acc_lat, line_marks.lat_neg, line_marks.lat_zero);
         stored_fix.lon    = signed_mag(acc_lon, line_marks.lon_neg, line_marks.lon_zero);
         stored_fix.date   = acc_date;
      end
      s.rec = stored_fix;
      expected_lines.push_back(s);
      clear_line();
   endfunction

   task automatic report_fault(string what);
      if (fault_total < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      fault_total++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_fault($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic compare_result();
      line_summary_type want;
      if (expected_lines.size() == 0) begin
         report_fault("result transfer with no line end waiting");
         return;
      end
      want = expected_lines.pop_front();
      check_field("sentence_ok", rsp_sentence_ok, want.ok);
      check_field("fix_valid", rsp_fix_valid, want.rec.fix);
      check_field("time_hhmmss", rsp_time_hhmmss, want.rec.time_int);
      check_field("time_millis", rsp_time_millis, want.rec.millis);
      check_field("latitude_e4", rsp_latitude_e4, want.rec.lat);
      check_field("longitude_e4", rsp_longitude_e4, want.rec.lon);
      check_field("date_ddmmyy", rsp_date_ddmmyy, want.rec.date);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         stored_fix = '0;
         expected_lines.delete();
         fault_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) compare_result();
         if (req_valid && req_ready && req_rx_byte != CHAR_DOLLAR) begin
            if (req_rx_byte == CHAR_LF) finish_line();
            else take_byte(req_rx_byte);
         end
      end
      lines_outstanding <= expected_lines.size();
   end

endmodule

>>> dv/testbench.sv
// Top of the RMC sentence parser bench: clock, reset, byte stream, output stalls and verdict.
`timescale 1ns / 100ps

module testbench;
   import nrmc_pkg::*;

   // This limit only catches a hang.
   localparam int CYCLE_LIMIT  = 600000;
   // Long receiver hold-off, long enough for a second newline to back up the input.
   localparam int LONG_HOLD    = 400;
   // A newline's result passes the input and result registers; wait well past that at the end.
   localparam int DRAIN_CYCLES = 16;
   localparam int LINES_PER_PHASE = 25;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic               rsp_sentence_ok;
   logic               rsp_fix_valid;
   logic [19:0]        rsp_time_hhmmss;
   logic [9:0]         rsp_time_millis;
   logic signed [31:0] rsp_latitude_e4;
   logic signed [31:0] rsp_longitude_e4;
   logic [19:0]        rsp_date_ddmmyy;

   int fault_total;
   int lines_outstanding;
   int cycle_count = 0;

   // Idle rates in percent. The sender's rate belongs to the stimulus process alone;
   // the receiver's rate is handed over with nonblocking writes.
   int send_gap = 0;
   int recv_gap = 0;

   // Each flip of the token starts one long receiver hold-off.
   logic hold_token = 1'b0;
   logic hold_seen  = 1'b0;
   int   hold_left  = 0;

   // Bytes of the line being assembled.
   logic [7:0] line_buf[$];

   nmea_rmc_sentence_parser_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sentence_ok  (rsp_sentence_ok),
      .rsp_fix_valid    (rsp_fix_valid),
      .rsp_time_hhmmss  (rsp_time_hhmmss),
      .rsp_time_millis  (rsp_time_millis),
      .rsp_latitude_e4  (rsp_latitude_e4),
      .rsp_longitude_e4 (rsp_longitude_e4),
      .rsp_date_ddmmyy  (rsp_date_ddmmyy)
   );

   rmc_line_checker line_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sentence_ok   (rsp_sentence_ok),
      .rsp_fix_valid     (rsp_fix_valid),
      .rsp_time_hhmmss   (rsp_time_hhmmss),
      .rsp_time_millis   (rsp_time_millis),
      .rsp_latitude_e4   (rsp_latitude_e4),
      .rsp_longitude_e4  (rsp_longitude_e4),
      .rsp_date_ddmmyy   (rsp_date_ddmmyy),
      .fault_total       (fault_total),
      .lines_outstanding (lines_outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result receiver. A token flip starts a long hold-off that this process counts down
   // on its own; otherwise ready follows the current idle rate.
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_gap);
      end
   end

   // Offers one byte, with random idle cycles in front, and returns at the edge that
   // completes its transfer. Valid is lowered only on idle cycles, so it never drops
   // between back-to-back bytes.
   task automatic push_byte(logic [7:0] c);
      while ($urandom_range(0, 99) < send_gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic emit_line();
      foreach (line_buf[i]) push_byte(line_buf[i]);
      line_buf.delete();
   endtask

   // Stops offering bytes and waits until every owed result has been taken.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lines_outstanding != 0) @(posedge clock);
   endtask

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_digit();
      logic [3:0] d;
      d = $urandom_range(0, 9);
      return CHAR_ZERO + {4'h0, d};
   endfunction

   function automatic void put_digits(int n);
      for (int i = 0; i < n; i++) line_buf.push_back(rand_digit());
   endfunction

   // Mostly the usual size, now and then anything up to the given bound.
   function automatic int pick(int usual, int most);
      if ($urandom_range(0, 99) < 85) return usual;
      return int'($urandom_range(0, most));
   endfunction

   // A number with optional fraction. Now and then a space, sign, exponent or second dot
   // lands in front or behind, which must end the number early.
   function automatic void put_number(int int_digits, int frac_digits, bit with_dot);
      string junk = " -+e.";
      if ($urandom_range(0, 99) < 6) line_buf.push_back(junk[$urandom_range(0, 4)]);
      put_digits(int_digits);
      if (with_dot) begin
         line_buf.push_back(CHAR_DOT);
         put_digits(frac_digits);
      end
      if ($urandom_range(0, 99) < 6) begin
         line_buf.push_back(junk[$urandom_range(0, 4)]);
         put_digits($urandom_range(0, 3));
      end
   endfunction

   // Status or hemisphere: one of the two legal letters mostly, else empty, a stray
   // character, or a legal letter with more characters after it.
   function automatic void put_mark(logic [7:0] a, logic [7:0] b);
      int unsigned r;
      logic [7:0]  x;
      r = $urandom_range(0, 99);
      x = $urandom_range(33, 126);
      if (r < 44) begin
         line_buf.push_back(a);
      end else if (r < 88) begin
         line_buf.push_back(b);
      end else if (r < 93) begin
         // Left empty.
      end else if (r < 97) begin
         line_buf.push_back(x);
      end else begin
         line_buf.push_back(a);
         line_buf.push_back(b);
      end
   endfunction

   // A complete RMC sentence with random content, up to but not including the newline.
   function automatic void put_sentence();
      string hex = "0123456789ABCDEF";
      int    r;
      if ($urandom_range(0, 99) < 90) line_buf.push_back(CHAR_DOLLAR);
      r = $urandom_range(0, 99);
      if (r < 88) put_text("GPRMC");
      else if (r < 92) put_text("GNRMC");
      else if (r < 96) put_text("GPRM");
      else put_text("XGPRMCY");
      line_buf.push_back(CHAR_COMMA);
      put_number(pick(6, 9), pick(2, 6), $urandom_range(0, 99) < 80);
      line_buf.push_back(CHAR_COMMA);
      put_mark(CHAR_A, CHAR_V);
      line_buf.push_back(CHAR_COMMA);
      put_number(pick(4, 12), pick(4, 8), $urandom_range(0, 99) < 85);
      line_buf.push_back(CHAR_COMMA);
      put_mark(CHAR_N, CHAR_S);
      line_buf.push_back(CHAR_COMMA);
      put_number(pick(5, 12), pick(4, 8), $urandom_range(0, 99) < 85);
      line_buf.push_back(CHAR_COMMA);
      put_mark(CHAR_E, CHAR_W);
      line_buf.push_back(CHAR_COMMA);
      put_number(3, 1, 1'b1);
      line_buf.push_back(CHAR_COMMA);
      put_number(3, 1, 1'b1);
      line_buf.push_back(CHAR_COMMA);
      // The date has no fraction; a dot here must stop the number.
      put_number(pick(6, 9), $urandom_range(0, 2), $urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 60) put_text(",003.1,W");
      else if (r < 80) put_text(",,A");
      line_buf.push_back(CHAR_STAR);
      line_buf.push_back(hex[$urandom_range(0, 15)]);
      line_buf.push_back(hex[$urandom_range(0, 15)]);
      // Without the carriage return the star sits one byte too late and the line fails.
      if ($urandom_range(0, 99) < 92) line_buf.push_back(CHAR_CR);
   endfunction

   // One random change to a sentence: drop, insert, overwrite or cut. Inserted and
   // overwritten bytes may be anything, a newline or a dollar sign included.
   function automatic void damage_line();
      int unsigned pos;
      logic [7:0]  x;
      pos = $urandom_range(0, line_buf.size() - 1);
      x   = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
         0: line_buf.delete(pos);
         1: line_buf.insert(pos, x);
         2: line_buf[pos] = x;
         default: begin
            while (line_buf.size() > pos) void'(line_buf.pop_back());
         end
      endcase
   endfunction

   // Mostly good sentences, some damaged ones, and some lines of raw noise.
   task automatic random_line();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         put_sentence();
         if (r >= 65) damage_line();
      end else begin
         repeat ($urandom_range(0, 24)) line_buf.push_back($urandom_range(0, 255));
      end
      line_buf.push_back(CHAR_LF);
      emit_line();
   endtask

   task automatic send_sentence(string text);
      put_text(text);
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
      emit_line();
   endtask

   initial begin
      send_gap = 12;
      recv_gap <= 79;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Plain fixes: active with north and east, then void with south and west at the
      // top of every field.
      send_sentence("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
      send_sentence("$GPRMC,235959.999,V,9000.0000,S,18000.0000,W,0.0,0.0,311299,,*00");
      // Empty hemispheres force the coordinates to zero.
      send_sentence("$GPRMC,000000,A,1234.5678,,12345.6789,,1,2,010100,,*00");
      // An empty status rejects the line and leaves the record as it was.
      send_sentence("$GPRMC,081836,,3751.65,S,14507.36,E,000.0,360.0,130998,011.3,E*62");
      // Saturation everywhere, with more fraction digits than are kept.
      send_sentence(
         "$GPRMC,99999999999.99999,A,999999999999.9999999,S,123456789012.1,W,1,2,99999999,,*00");
      // Leading space, sign and exponent end numbers early; a dot ends the date.
      send_sentence("$GPRMC, 123519,A,-4807.038,N,1e5,E,1,2,230394.77,,*00");
      send_sentence("$GPRMC,1.23456789,A,12.,N,.5,E,1,2,12.34,,*00");
      // Eight commas are too few; exactly nine are enough.
      send_sentence("$GPRMC,123519,A,4807.038,N,01131.000,E,1,2*00");
      send_sentence("$GPRMC,1,A,1,N,1,E,1,1,7*00");
      // Only the first character of status and hemisphere is checked.
      send_sentence("$GPRMC,1.5,AV,1.25,NS,2.5,EW,,,050505,,*00");
      // A bad status letter and a bad hemisphere letter each reject the line.
      send_sentence("$GPRMC,1,X,1,N,1,E,,,1,,*00");
      send_sentence("$GPRMC,1,A,1,Q,1,E,,,1,,*00");
      // The tag may stand anywhere, and a dollar sign inside it is simply dropped.
      send_sentence("XX,1,A,2,N,3,E,,,4,GPRMC,*00");
      send_sentence("$GP$RMC,2,V,3,S,4,W,,,5,,*00");
      // Zero byte in the time field and high bytes in an ignored field.
      put_text("$GPRMC,12");
      line_buf.push_back(8'h00);
      put_text("34,A,1,N,2,E,");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      put_text(",7,080808,,*00");
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
      emit_line();
      // Very long line with the comma count saturated.
      put_text("$GPRMC,3,A,4,S,5,W,6,7,8,");
      repeat (300) line_buf.push_back(rand_digit());
      repeat (20) line_buf.push_back(CHAR_COMMA);
      put_text("*00");
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
      emit_line();
      // No carriage return, so the star is three bytes from the end.
      put_text("$GPRMC,1,A,1,N,1,E,1,1,1,,*6A");
      line_buf.push_back(CHAR_LF);
      emit_line();
      // Short lines: empty, one byte, three bytes, and four bytes without the tag.
      line_buf.push_back(CHAR_LF);
      line_buf.push_back(CHAR_STAR);
      line_buf.push_back(CHAR_LF);
      put_text("*ab");
      line_buf.push_back(CHAR_LF);
      put_text("*abc");
      line_buf.push_back(CHAR_LF);
      emit_line();
      pause_until_drained();

      // Slow receiver. Midway it holds off for a long stretch while short lines keep
      // coming, so a second newline backs up and the input stalls.
      for (int i = 0; i < LINES_PER_PHASE; i++) random_line();
      hold_token <= ~hold_token;
      for (int i = 0; i < 8; i++) begin
         put_text("$GPRMC,1,A,2,N,3,E,,,4,,*00");
         line_buf.push_back(CHAR_CR);
         line_buf.push_back(CHAR_LF);
         emit_line();
         random_line();
      end
      pause_until_drained();

      // Slow sender, eager receiver.
      send_gap = 79;
      recv_gap <= 12;
      for (int i = 0; i < LINES_PER_PHASE; i++) random_line();
      pause_until_drained();

      // Full rate on both sides.
      send_gap = 0;
      recv_gap <= 0;
      for (int i = 0; i < LINES_PER_PHASE; i++) random_line();

      req_valid <= 1'b0;
      @(posedge clock);
      while (lines_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_total == 0 && lines_outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/nrmc_pkg.sv
rtl/core/nrmc_line_parser.sv
rtl/core/nrmc_fix_record.sv
rtl/core/nmea_rmc_sentence_parser_unit.sv
rtl/core/nrmc_checker.sv
dv/rmc_line_checker.sv
dv/testbench.sv
